@@ src/rlzd_pkg.sv @@
// Shared types, constants and the controller/datapath interface for the
// run-length and back-reference byte decompressor. No dependencies.
package rlzd_pkg;

  // History window and output limit.
  localparam int unsigned HIST_AW        = 8;
  localparam int unsigned HIST_DEPTH     = 1 << HIST_AW;
  localparam int unsigned MAX_OUTPUT_DEF = 65536;
  localparam int unsigned LIMIT_W        = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  // Count field of literal and back-copy control bytes.
  localparam logic [5:0] COUNT_MASK = 6'h3F;

  // Status codes reported on the final result of a stream.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC     = 2'd1,
    ST_BAD_DIST  = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // One compressed byte request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  // One decoded result request.
  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [1:0] byte_count;
    logic [1:0] status;
    logic       run_end;
    logic       stream_done;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;      // latch the incoming byte
    logic    fresh;       // start a fresh stream (clear written count)
    logic    load_pend;   // load the pending count from the control byte
    logic    emit;        // decode one byte into history and pair buffer
    logic    copy_sel;    // emitted byte comes from the history read
    logic    rd_init;     // issue the first history read of a back copy
    logic    push_final;  // send the closing result of this input
    status_e err;         // status for the closing result
    logic    ended;       // stream finished or failed on this input
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [7:0] cur_byte;
    logic       last;
    logic       pend_zero;
    logic       pend_one;
    logic       overflow;
    logic       dist_bad;
    logic       acc_full;
    logic       acc_empty;
    logic       out_free;
  } status_t;

endpackage

@@ src/rlzd_ctrl.sv @@
// Controller of the decompressor: stream phase tracking and the per-request
// sequencing state machine. Depends on rlzd_pkg.
module rlzd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_last_i,
  input  rlzd_pkg::status_t status_i,
  output rlzd_pkg::cmd_t    cmd_o
);
  import rlzd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_PRIME    = 6'b000100,
    S_EMIT     = 6'b001000,
    S_FINAL    = 6'b010000,
    S_SPARE    = 6'b100000
  } state_e;

  typedef enum logic [3:0] {
    PH_CTRL = 4'b0001,
    PH_RUN  = 4'b0010,
    PH_LIT  = 4'b0100,
    PH_DIST = 4'b1000
  } phase_e;

  state_e  state_q, state_d;
  phase_e  phase_q, phase_d;
  logic    finished_q, finished_d;
  logic    lit_q, lit_d;
  logic    copy_q, copy_d;
  status_e err_q, err_d;
  logic    ended_q, ended_d;

  // Next-state and command logic.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    finished_d = finished_q;
    lit_d      = lit_q;
    copy_d     = copy_q;
    err_d      = err_q;
    ended_d    = ended_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.err  = err_q;
    cmd_o.ended = ended_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (finished_q) begin
            // Dropped byte; a last flag restarts the stream.
            if (in_last_i) begin
              cmd_o.fresh = 1'b1;
              finished_d  = 1'b0;
              phase_d     = PH_CTRL;
            end
          end else begin
            state_d = S_DISPATCH;
          end
        end
      end

      S_DISPATCH: begin
        state_d = S_FINAL;
        ended_d = status_i.last;
        err_d   = status_i.last ? ST_TRUNC : ST_OK;
        lit_d   = 1'b0;
        copy_d  = 1'b0;
        case (phase_q)
          PH_CTRL: begin
            if (status_i.cur_byte == 8'd0) begin
              ended_d = 1'b1;
              err_d   = ST_OK;
            end else begin
              cmd_o.load_pend = 1'b1;
              if (!status_i.cur_byte[7]) begin
                phase_d = PH_RUN;
              end else if (!status_i.cur_byte[6]) begin
                phase_d = ((status_i.cur_byte[5:0] & COUNT_MASK) != 6'd0) ? PH_LIT : PH_CTRL;
              end else begin
                phase_d = PH_DIST;
              end
            end
          end
          PH_RUN: begin
            phase_d = PH_CTRL;
            state_d = S_EMIT;
          end
          PH_LIT: begin
            lit_d   = 1'b1;
            state_d = S_EMIT;
          end
          PH_DIST: begin
            phase_d = PH_CTRL;
            if (status_i.pend_zero) begin
              state_d = S_FINAL;
            end else if (status_i.dist_bad) begin
              ended_d = 1'b1;
              err_d   = ST_BAD_DIST;
            end else begin
              state_d = S_PRIME;
            end
          end
          default: begin
            phase_d = PH_CTRL;
          end
        endcase
      end

      S_PRIME: begin
        // First history read of the back copy; data is ready next cycle.
        cmd_o.rd_init = 1'b1;
        copy_d        = 1'b1;
        state_d       = S_EMIT;
      end

      S_EMIT: begin
        cmd_o.copy_sel = copy_q;
        if (status_i.overflow) begin
          ended_d = 1'b1;
          err_d   = ST_OVERFLOW;
          state_d = S_FINAL;
        end else if (!status_i.acc_full || status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (lit_q || status_i.pend_one) begin
            ended_d = status_i.last;
            err_d   = status_i.last ? ST_TRUNC : ST_OK;
            state_d = S_FINAL;
            if (lit_q) begin
              phase_d = status_i.pend_one ? PH_CTRL : PH_LIT;
            end
          end
        end
      end

      S_FINAL: begin
        if (status_i.acc_empty && !ended_q) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.push_final = 1'b1;
          state_d          = S_IDLE;
          if (ended_q) begin
            phase_d = PH_CTRL;
            if (status_i.last) begin
              cmd_o.fresh = 1'b1;
              finished_d  = 1'b0;
            end else begin
              finished_d  = 1'b1;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_CTRL;
      finished_q <= 1'b0;
      lit_q      <= 1'b0;
      copy_q     <= 1'b0;
      err_q      <= ST_OK;
      ended_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      finished_q <= finished_d;
      lit_q      <= lit_d;
      copy_q     <= copy_d;
      err_q      <= err_d;
      ended_q    <= ended_d;
    end
  end

  // A stream that has ended always waits in the control phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (phase_q == PH_CTRL))
    else $error("finished stream outside control phase");

  // A back-copy emit is always preceded by a primed history read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRIME) |=> (state_q == S_EMIT && copy_q))
    else $error("back copy not primed");

endmodule

@@ src/rlzd_dpath.sv @@
// Datapath of the decompressor: byte and count registers, the 256-byte
// history memory, pair packing and the output register. Depends on rlzd_pkg.
module rlzd_dpath #(
  parameter int unsigned MAX_OUTPUT = rlzd_pkg::MAX_OUTPUT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rlzd_pkg::in_item_t           in_data_i,
  input  rlzd_pkg::cmd_t               cmd_i,
  output rlzd_pkg::status_t            status_o,
  input  logic                         cfg_we_i,
  input  logic [rlzd_pkg::LIMIT_W-1:0] cfg_wdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rlzd_pkg::out_item_t          out_data_o
);
  import rlzd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_OUTPUT + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [7:0]         byte_q;
  logic               last_q;
  logic [6:0]         pend_q;
  logic [CW-1:0]      wc_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [7:0]         acc0_q, acc1_q;
  logic [1:0]         acc_cnt_q;
  logic [7:0]         rd_q;
  logic [HIST_AW-1:0] rp_q;
  logic               out_valid_q;
  out_item_t          out_q;
  logic [7:0]         mem [HIST_DEPTH];

  logic [LW-1:0]      lim;
  logic [7:0]         emit_byte;
  logic               rd_en;
  logic [HIST_AW-1:0] raddr;
  logic [HIST_AW-1:0] waddr;
  logic               out_free;
  logic               push_pair;

  // Limit in use and the checks the controller needs.
  assign lim = (LW'(limit_q) > LW'(MAX_OUTPUT)) ? LW'(MAX_OUTPUT) : LW'(limit_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_byte = cmd_i.copy_sel ? rd_q : byte_q;
  assign push_pair = cmd_i.emit && (acc_cnt_q == 2'd2);

  assign status_o.cur_byte  = byte_q;
  assign status_o.last      = last_q;
  assign status_o.pend_zero = (pend_q == 7'd0);
  assign status_o.pend_one  = (pend_q == 7'd1);
  assign status_o.overflow  = (LW'(wc_q) >= lim);
  assign status_o.dist_bad  = (byte_q == 8'd0) || (CW'(byte_q) > wc_q);
  assign status_o.acc_full  = (acc_cnt_q == 2'd2);
  assign status_o.acc_empty = (acc_cnt_q == 2'd0);
  assign status_o.out_free  = out_free;

  // History addressing: reads walk forward from the copy start.
  assign waddr = wc_q[HIST_AW-1:0];
  assign raddr = cmd_i.rd_init ? (waddr - byte_q[HIST_AW-1:0]) : rp_q;
  assign rd_en = cmd_i.rd_init || (cmd_i.emit && cmd_i.copy_sel);

  // History memory with write-to-read forwarding for distance one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mem[waddr] <= emit_byte;
    end
    if (rd_en) begin
      if (cmd_i.emit && (waddr == raddr)) begin
        rd_q <= emit_byte;
      end else begin
        rd_q <= mem[raddr];
      end
      rp_q <= raddr + HIST_AW'(1);
    end
  end

  // Payload registers: current byte, pair buffer and result contents.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_data_i.in_byte;
      last_q <= in_data_i.last_byte;
    end
    if (cmd_i.emit) begin
      if (acc_cnt_q == 2'd1) begin
        acc1_q <= emit_byte;
      end else begin
        acc0_q <= emit_byte;
      end
    end
    if (push_pair) begin
      out_q <= '{byte_first: acc0_q, byte_second: acc1_q, byte_count: 2'd2,
                 status: ST_OK, run_end: 1'b0, stream_done: 1'b0};
    end else if (cmd_i.push_final) begin
      out_q <= '{byte_first:  (acc_cnt_q != 2'd0) ? acc0_q : 8'd0,
                 byte_second: (acc_cnt_q == 2'd2) ? acc1_q : 8'd0,
                 byte_count:  acc_cnt_q,
                 status:      cmd_i.err,
                 run_end:     1'b1,
                 stream_done: cmd_i.ended};
    end
  end

  // Control registers: counts, limit and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      wc_q        <= '0;
      limit_q     <= LIMIT_RESET;
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load_pend) begin
        pend_q <= byte_q[7] ? {1'b0, byte_q[5:0] & COUNT_MASK} : byte_q[6:0];
      end else if (cmd_i.emit) begin
        pend_q <= pend_q - 7'd1;
      end
      if (cmd_i.fresh) begin
        wc_q <= '0;
      end else if (cmd_i.emit) begin
        wc_q <= wc_q + CW'(1);
      end
      if (cmd_i.emit) begin
        acc_cnt_q <= (acc_cnt_q == 2'd2) ? 2'd1 : acc_cnt_q + 2'd1;
      end else if (cmd_i.push_final) begin
        acc_cnt_q <= 2'd0;
      end
      if (push_pair || cmd_i.push_final) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Emitting and closing never share a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit && cmd_i.push_final))
    else $error("emit and final push together");

  // A new result never overwrites one still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_pair || cmd_i.push_final) |-> out_free)
    else $error("result overwritten");

  // No byte is decoded past the output limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (LW'(wc_q) < lim))
    else $error("byte decoded past limit");

endmodule

@@ src/rle_lz_byte_decompressor.sv @@
// Top level of the run-length / back-reference byte decompressor.
// Each accepted byte is dispatched and decoded into bytes where it carries them (a back copy first
// primes its history read); a closing result goes to the output register if bytes wait or the stream ends.
// Decoding runs at one decoded byte per cycle while the output is not stalled.
// A new input byte is accepted only once the block has finished with the previous one.
// Reset clears the control state and sets the output limit to 65536; the history is not cleared.
// Depends on rlzd_pkg, rlzd_ctrl and rlzd_dpath.
module rle_lz_byte_decompressor #(
  parameter int unsigned MAX_OUTPUT = rlzd_pkg::MAX_OUTPUT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rlzd_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rlzd_pkg::out_item_t          out_data_o,
  input  logic                         cfg_we_i,
  input  logic [rlzd_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import rlzd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing controller.
  rlzd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_last_i  (in_data_i.last_byte),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath with history and output register.
  rlzd_dpath #(
    .MAX_OUTPUT (MAX_OUTPUT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
